FILE: src/hsi_pkg.sv
// Shared types and constants for the RGB to HSI channel view pipeline.
package hsi_pkg;

  localparam logic [1:0] MODE_HUE = 2'd0;
  localparam logic [1:0] MODE_SAT = 2'd1;
  localparam logic [1:0] MODE_INT = 2'd2;

  localparam logic [9:0] INT_DEN = 10'd765;
  localparam logic [17:0] HUE_FULL = 18'd384;

  localparam int unsigned DivSteps = 9;

  // Three division lanes, one per output channel.
  typedef struct packed {
    logic [2:0][19:0] rem;
    logic [2:0][19:0] dsh;
    logic [2:0][8:0]  quo;
  } div_t;

endpackage

FILE: src/rgb_to_hsi_channel_view.sv
// Top level of the RGB to HSI channel view: config register, setup stages, divider chain.
//
//   Channel  Direction  Width  Contents
//   s_*      in         24     red [7:0], green [15:8], blue [23:16]
//   m_*      out        32     out_red [8:0], out_green [17:9], out_blue [26:18]
//   cfg_*    in         2      display_mode
//
// One pixel request is taken every clock while m_tready does not stall the pipe; each
// result passes through three setup stages and nine one-bit divider stages.
// Reset clears every valid bit and sets display_mode to the hue view.
// Each stage holds its data while the next one is full and stalled, so a stall
// at m_tready backs up stage by stage and bubbles are squeezed out.
module rgb_to_hsi_channel_view (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red, green, blue from bit 0 up
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_red, out_green, out_blue from bit 0 up, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import hsi_pkg::*;

  logic [1:0] display_mode;

  logic [DivSteps:0] valid;
  logic [DivSteps:0] ready;
  div_t              data [DivSteps+1];

  // The mode register is sampled together with each pixel, so it travels down the
  // pipe with its request.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= MODE_HUE;
    end else if (cfg_valid) begin
      display_mode <= cfg_data;
    end
  end

  hsi_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .mode      (display_mode),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_data  (data[0])
  );

  // Each stage resolves one quotient bit, most significant first.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    hsi_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .in_data   (data[k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .out_data  (data[k+1])
    );
  end

  // The last divider stage is the output register.
  assign ready[DivSteps] = m_tready;
  assign m_tvalid        = valid[DivSteps];
  assign m_tdata         = {5'b0, data[DivSteps].quo[2], data[DivSteps].quo[1],
                            data[DivSteps].quo[0]};

endmodule

FILE: src/hsi_prep.sv
// Front stages: pixel register, minimum and sum, then numerator and divisor setup.
module hsi_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [1:0]         mode,
  output logic               out_valid,
  input  logic               out_ready,
  output hsi_pkg::div_t      out_data
);
  import hsi_pkg::*;

  logic       a_valid;
  logic [2:0][7:0] a_c;
  logic [1:0] a_mode;
  logic       a_ready;

  logic       b_valid;
  logic [2:0][7:0] b_diff;
  logic [9:0] b_sum;
  logic [1:0] b_mode;
  logic       b_ready;

  logic [7:0] a_min;
  logic [9:0] d0;
  div_t       c_next;

  assign a_ready  = !b_valid || b_ready;
  assign in_ready = !a_valid || a_ready;
  assign b_ready  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_c[0] <= red;
      a_c[1] <= green;
      a_c[2] <= blue;
      a_mode <= mode;
    end
  end

  always_comb begin
    a_min = a_c[0];
    if (a_c[1] < a_min) a_min = a_c[1];
    if (a_c[2] < a_min) a_min = a_c[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_ready) begin
      b_valid <= a_valid;
    end
    if (a_ready && a_valid) begin
      for (int i = 0; i < 3; i++) begin
        b_diff[i] <= a_c[i] - a_min;
      end
      b_sum  <= {2'b00, a_c[0]} + {2'b00, a_c[1]} + {2'b00, a_c[2]};
      b_mode <= a_mode;
    end
  end

  // The spread sum - 3*min is the sum of the per-channel distances to the minimum.
  assign d0 = {2'b00, b_diff[0]} + {2'b00, b_diff[1]} + {2'b00, b_diff[2]};

  always_comb begin
    logic [17:0] n;
    logic [9:0]  d;
    c_next = '0;
    for (int i = 0; i < 3; i++) begin
      n = '0;
      d = 10'd1;
      case (b_mode)
        MODE_HUE: begin
          if (d0 == 10'd0) begin
            n = (i == 0) ? HUE_FULL : 18'd0;
          end else begin
            n = {2'b00, b_diff[i], 8'b0} + {3'b000, b_diff[i], 7'b0};
            d = d0;
          end
        end
        MODE_SAT: begin
          if (b_sum != 10'd0) begin
            n = {d0, 8'b0};
            d = b_sum;
          end
        end
        default: begin
          n = {b_sum, 8'b0};
          d = INT_DEN;
        end
      endcase
      // Round to nearest, ties up: (2n + d) / (2d).
      c_next.rem[i] = {1'b0, n, 1'b0} + {10'b0, d};
      c_next.dsh[i] = {1'b0, d, 9'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= b_valid;
    end
    if (b_ready && b_valid) begin
      out_data <= c_next;
    end
  end

endmodule

FILE: src/hsi_div_stage.sv
// One restoring division step on three lanes, producing one quotient bit per lane.
module hsi_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hsi_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hsi_pkg::div_t out_data
);
  import hsi_pkg::*;

  div_t step;

  assign in_ready = !out_valid || out_ready;

  // The divisor is held shifted to the top quotient bit; the remainder shifts left instead.
  always_comb begin
    logic        ge;
    logic [19:0] left;
    step = in_data;
    for (int i = 0; i < 3; i++) begin
      ge   = in_data.rem[i] >= in_data.dsh[i];
      left = ge ? (in_data.rem[i] - in_data.dsh[i]) : in_data.rem[i];
      step.rem[i] = {left[18:0], 1'b0};
      step.quo[i] = {in_data.quo[i][7:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= step;
    end
  end

endmodule
